// ----- hw/rtl/sem_pkg.sv -----
package sem_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  localparam int unsigned PixW = 8;
  localparam int unsigned CfgW = 11;
  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowW = $clog2(MaxHeight);
  localparam int unsigned SumW = PixW + 2;
  localparam int unsigned MagW = 8;

  localparam logic [CfgW-1:0] MinSize         = CfgW'(3);
  localparam logic [CfgW-1:0] WidthReset      = CfgW'(640);
  localparam logic [CfgW-1:0] HeightReset     = CfgW'(480);
  localparam logic [MagW-1:0] MagSat          = MagW'(255);

  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  typedef struct packed {
    logic            re;
    logic [ColW-1:0] raddr;
    logic            we;
    logic [ColW-1:0] waddr;
    logic [2*PixW-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

  function automatic logic [CfgW-1:0] clamp_size(input logic [CfgW-1:0] v,
                                                 input logic [CfgW-1:0] hi);
    logic [CfgW-1:0] r;
    if (v < MinSize) begin
      r = MinSize;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/sem_line_buf.sv -----
module sem_line_buf (
  input  logic                            clk_i,
  input  sem_pkg::mem_req_t               req_i,
  output logic [2*sem_pkg::PixW-1:0]      rdata_o
);

  logic [2*sem_pkg::PixW-1:0] mem [sem_pkg::MaxWidth];
  logic [2*sem_pkg::PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/sem_window.sv -----
module sem_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sem_pkg::win_ctrl_t          ctrl_i,
  input  logic [sem_pkg::PixW-1:0]    top_i,
  input  logic [sem_pkg::PixW-1:0]    mid_i,
  input  logic [sem_pkg::PixW-1:0]    bot_i,
  output logic [sem_pkg::MagW-1:0]    magnitude_o
);

  logic [sem_pkg::PixW-1:0] lt_q, lm_q, lb_q, mt_q, mm_q, mb_q;
  logic [sem_pkg::SumW-1:0] left, right, top, bottom, gx, gy;
  logic [sem_pkg::SumW:0]   mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= '0;
      lm_q <= '0;
      lb_q <= '0;
      mt_q <= '0;
      mm_q <= '0;
      mb_q <= '0;
    end else if (ctrl_i.clear) begin
      lt_q <= '0;
      lm_q <= '0;
      lb_q <= '0;
      mt_q <= '0;
      mm_q <= '0;
      mb_q <= '0;
    end else if (ctrl_i.shift) begin
      lt_q <= mt_q;
      lm_q <= mm_q;
      lb_q <= mb_q;
      mt_q <= top_i;
      mm_q <= mid_i;
      mb_q <= bot_i;
    end
  end

  always_comb begin
    left   = sem_pkg::SumW'(lt_q) + {1'b0, lm_q, 1'b0} + sem_pkg::SumW'(lb_q);
    right  = sem_pkg::SumW'(top_i) + {1'b0, mid_i, 1'b0} + sem_pkg::SumW'(bot_i);
    bottom = sem_pkg::SumW'(lb_q) + {1'b0, mb_q, 1'b0} + sem_pkg::SumW'(bot_i);
    top    = sem_pkg::SumW'(lt_q) + {1'b0, mt_q, 1'b0} + sem_pkg::SumW'(top_i);
    gx     = (left >= right) ? (left - right) : (right - left);
    gy     = (bottom >= top) ? (bottom - top) : (top - bottom);
    mag    = {1'b0, gx} + {1'b0, gy};
    if (mag > (sem_pkg::SumW + 1)'(sem_pkg::MagSat)) begin
      magnitude_o = sem_pkg::MagSat;
    end else begin
      magnitude_o = mag[sem_pkg::MagW-1:0];
    end
  end

endmodule

// ----- hw/rtl/sobel_edge_magnitude_top.sv -----
// Sobel edge magnitude: grey pixels enter in raster order at one per clock while the
// output is not stalled, and each interior pixel leaves as |Gx|+|Gy| saturated to 255
// with its row and column; border pixels produce nothing. A pixel passes through the
// read of the line store (a single 1024-entry memory holding the two rows above), then
// the window update and gradient arithmetic, and then the output register. The result
// for centre (r, c) is produced by the arrival of pixel (r+1, c+1). Writing either size
// register restarts the frame; sizes below 3 act as 3 and above 1024 as 1024.
module sobel_edge_magnitude_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] pixel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] magnitude, [17:8] row, [27:18] column
  output logic        m_axis_tlast_o,   // frame_end
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned PixW = sem_pkg::PixW;
  localparam int unsigned CfgW = sem_pkg::CfgW;
  localparam int unsigned ColW = sem_pkg::ColW;
  localparam int unsigned RowW = sem_pkg::RowW;
  localparam int unsigned MagW = sem_pkg::MagW;

  logic [CfgW-1:0] width_q, height_q, w_eff, h_eff;
  logic            cfg_wr;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            col_last, row_last, accept;

  logic            s1_valid_q, s1_emit_q, s1_last_q, s1_go;
  logic [PixW-1:0] s1_px_q;
  logic [ColW-1:0] s1_col_q, s1_ocol_q;
  logic [RowW-1:0] s1_orow_q;

  logic            out_valid_q, out_free;
  logic [MagW-1:0] out_mag_q, mag;
  logic [RowW-1:0] out_row_q;
  logic [ColW-1:0] out_col_q;
  logic            out_last_q;

  sem_pkg::mem_req_t          mem_req;
  sem_pkg::win_ctrl_t         win_ctrl;
  logic [2*PixW-1:0]          mem_rdata;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i & pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sem_pkg::WidthReset;
      height_q <= sem_pkg::HeightReset;
    end else if (cfg_wr) begin
      if (paddr_i[2] == sem_pkg::RegFrameWidth) begin
        width_q <= pwdata_i[CfgW-1:0];
      end else begin
        height_q <= pwdata_i[CfgW-1:0];
      end
    end
  end

  always_comb begin
    case (paddr_i[2])
      sem_pkg::RegFrameWidth:  prdata_o = {{(32-CfgW){1'b0}}, width_q};
      sem_pkg::RegFrameHeight: prdata_o = {{(32-CfgW){1'b0}}, height_q};
      default:                 prdata_o = '0;
    endcase
  end

  assign w_eff = sem_pkg::clamp_size(width_q, CfgW'(sem_pkg::MaxWidth));
  assign h_eff = sem_pkg::clamp_size(height_q, CfgW'(sem_pkg::MaxHeight));

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_go           = s1_valid_q && (out_free || !s1_emit_q);
  assign s_axis_tready_o = !s1_valid_q || s1_go;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign col_last = ({1'b0, col_q} + CfgW'(1)) >= w_eff;
  assign row_last = ({1'b0, row_q} + CfgW'(1)) >= h_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= s_axis_tdata_i;
      s1_col_q  <= col_q;
      s1_emit_q <= (row_q >= RowW'(2)) && (col_q >= ColW'(2));
      s1_orow_q <= row_q - RowW'(1);
      s1_ocol_q <= col_q - ColW'(1);
      s1_last_q <= row_last && col_last;
    end
  end

  always_comb begin
    mem_req.re    = accept;
    mem_req.raddr = col_q;
    mem_req.we    = s1_go;
    mem_req.waddr = s1_col_q;
    mem_req.wdata = {mem_rdata[PixW-1:0], s1_px_q};
  end

  sem_line_buf u_line_buf (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign win_ctrl.shift = s1_go;
  assign win_ctrl.clear = cfg_wr;

  sem_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (win_ctrl),
    .top_i       (mem_rdata[2*PixW-1:PixW]),
    .mid_i       (mem_rdata[PixW-1:0]),
    .bot_i       (s1_px_q),
    .magnitude_o (mag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_emit_q) begin
      out_mag_q  <= mag;
      out_row_q  <= s1_orow_q;
      out_col_q  <= s1_ocol_q;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_col_q, out_row_q, out_mag_q};
  assign m_axis_tlast_o  = out_last_q;

  a_no_addr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.re && mem_req.we) |-> (mem_req.raddr != mem_req.waddr))
    else $error("Line store read and write hit the same column.");

  a_rdata_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> $stable(mem_rdata))
    else $error("Line store data changed while its pixel was stalled.");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < w_eff) && ({1'b0, row_q} < h_eff))
    else $error("Pixel position left the frame.");

endmodule
